@@ hw/rtl/lpfb_pkg.sv @@
// lpfb_pkg: shared constants and types for the led pwm fade bargraph block
// no dependencies; used by the interfaces, lpfb_fade, lpfb_pwm and the top level
package lpfb_pkg;

  // default sizes, handed to the top level parameters
  localparam int BAR_SEGMENTS_DEF = 16;
  localparam int BUTTON_LEDS_DEF  = 5;
  localparam int DUTY_STEPS_DEF   = 8;

  // fixed field widths
  localparam int LEVEL_W  = 4;
  localparam int PERIOD_W = 8;
  localparam int SWEEP_W  = 8;
  localparam int LOW_LEDS = 2;

  // low segment bit positions
  localparam int LOW_WATER = 0;
  localparam int LOW_FOAM  = 1;

  // button led that blinks
  localparam int BLINK_LED = 4;

  // sweep encoding: bit 7 rising, low nibble is the shown level
  localparam logic [SWEEP_W-1:0] SWEEP_RISING = 8'h80;
  localparam logic [3:0]         SWEEP_TOP    = 4'h8;

  localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RESET = 8'd20;

  // item commands
  localparam logic CMD_FAST = 1'b0;
  localparam logic CMD_SLOW = 1'b1;

  // controls for one slow tick
  typedef struct packed {
    logic tick;
    logic power_on;
    logic start_water;
    logic start_foam;
  } fade_ctrl_t;

endpackage

@@ hw/rtl/lpfb_if.sv @@
// lpfb_item_if and lpfb_result_if: valid/ready channels of the bargraph block
// depends on lpfb_pkg for default sizes and field widths
interface lpfb_item_if #(
  parameter int BUTTON_LEDS = lpfb_pkg::BUTTON_LEDS_DEF
) ();
  logic                         valid;
  logic                         ready;
  logic                         cmd;
  logic [BUTTON_LEDS-1:0]       button_targets;
  logic [lpfb_pkg::LEVEL_W-1:0] water_level;
  logic [lpfb_pkg::LEVEL_W-1:0] foam_level;
  logic                         power_on;
  logic                         start_water_anim;
  logic                         start_foam_anim;

  modport source (
    output valid, cmd, button_targets, water_level, foam_level, power_on,
           start_water_anim, start_foam_anim,
    input  ready
  );
  modport sink (
    input  valid, cmd, button_targets, water_level, foam_level, power_on,
           start_water_anim, start_foam_anim,
    output ready
  );
endinterface

interface lpfb_result_if #(
  parameter int BUTTON_LEDS  = lpfb_pkg::BUTTON_LEDS_DEF,
  parameter int BAR_SEGMENTS = lpfb_pkg::BAR_SEGMENTS_DEF
) ();
  logic                          valid;
  logic                          ready;
  logic [BUTTON_LEDS-1:0]        button_leds;
  logic [lpfb_pkg::LOW_LEDS-1:0] low_leds;
  logic [BAR_SEGMENTS-1:0]       bar_leds;

  modport source (output valid, button_leds, low_leds, bar_leds, input ready);
  modport sink (input valid, button_leds, low_leds, bar_leds, output ready);
endinterface

@@ hw/rtl/lpfb_fade.sv @@
// lpfb_fade: blink timer, scale sweeps and duty ramps, updated on slow ticks
// depends on lpfb_pkg
module lpfb_fade #(
  parameter int BAR_SEGMENTS = lpfb_pkg::BAR_SEGMENTS_DEF,
  parameter int BUTTON_LEDS  = lpfb_pkg::BUTTON_LEDS_DEF,
  parameter int DUTY_STEPS   = lpfb_pkg::DUTY_STEPS_DEF,
  localparam int DW = $clog2(DUTY_STEPS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  lpfb_pkg::fade_ctrl_t          ctrl,
  input  logic [lpfb_pkg::PERIOD_W-1:0] blink_half_period,
  input  logic [BUTTON_LEDS-1:0]        button_targets,
  input  logic [lpfb_pkg::LEVEL_W-1:0]  water_level,
  input  logic [lpfb_pkg::LEVEL_W-1:0]  foam_level,
  output logic [DW-1:0]                 button_duty [BUTTON_LEDS],
  output logic [DW-1:0]                 low_duty [lpfb_pkg::LOW_LEDS],
  output logic [DW-1:0]                 bar_duty [BAR_SEGMENTS]
);

  localparam int SEG_W = $clog2(BAR_SEGMENTS + 1);
  localparam int CMP_W = (SEG_W > lpfb_pkg::LEVEL_W) ? SEG_W : lpfb_pkg::LEVEL_W;

  function automatic logic [DW-1:0] ramp(input logic [DW-1:0] d, input logic on);
    logic [DW-1:0] r;
    r = d;
    if (on) begin
      if (d < DW'(DUTY_STEPS)) r = d + 1'b1;
    end else if (d != '0) begin
      r = d - 1'b1;
    end
    return r;
  endfunction

  function automatic logic [lpfb_pkg::SWEEP_W-1:0] sweep_step(
    input logic [lpfb_pkg::SWEEP_W-1:0] s
  );
    logic [lpfb_pkg::SWEEP_W-1:0] r;
    r = s;
    if ((s & lpfb_pkg::SWEEP_RISING) == '0) begin
      if (s != '0) r = s - 1'b1;
    end else begin
      r = s + 1'b1;
      if (r[3:0] == lpfb_pkg::SWEEP_TOP) r = r & ~lpfb_pkg::SWEEP_RISING;
    end
    return r;
  endfunction

  logic [lpfb_pkg::PERIOD_W-1:0] blink_count, blink_count_next;
  logic                          blink_flag, blink_flag_next;
  logic [lpfb_pkg::SWEEP_W-1:0]  water_sweep, foam_sweep;
  logic [lpfb_pkg::SWEEP_W-1:0]  water_step, foam_step;
  logic [lpfb_pkg::PERIOD_W:0]   count_inc;
  logic [lpfb_pkg::LEVEL_W-1:0]  water_fill, foam_fill;
  logic [BUTTON_LEDS-1:0]        button_on;
  logic [lpfb_pkg::LOW_LEDS-1:0] low_on;
  logic [BAR_SEGMENTS-1:0]       bar_on;

  // blink timer
  always_comb begin
    count_inc = {1'b0, blink_count} + 1'b1;
    if (count_inc >= {1'b0, blink_half_period}) begin
      blink_count_next = '0;
      blink_flag_next  = ~blink_flag;
    end else begin
      blink_count_next = count_inc[lpfb_pkg::PERIOD_W-1:0];
      blink_flag_next  = blink_flag;
    end
  end

  assign water_step = sweep_step(water_sweep);
  assign foam_step  = sweep_step(foam_sweep);

  // an active sweep overrides the level
  assign water_fill = (water_step != '0) ? water_step[3:0] : water_level;
  assign foam_fill  = (foam_step != '0) ? foam_step[3:0] : foam_level;

  assign low_on[lpfb_pkg::LOW_WATER] = (water_level == '0) && (water_step == '0) &&
                                       blink_flag_next && ctrl.power_on;
  assign low_on[lpfb_pkg::LOW_FOAM]  = (foam_level == '0) && (foam_step == '0) &&
                                       blink_flag_next && ctrl.power_on;

  for (genvar i = 0; i < BUTTON_LEDS; i++) begin : g_btn_on
    if (i == lpfb_pkg::BLINK_LED) begin : g_blink
      assign button_on[i] = button_targets[i] & blink_flag_next;
    end else begin : g_plain
      assign button_on[i] = button_targets[i];
    end
  end

  // water fills from segment 0 up, foam from the top down
  for (genvar i = 0; i < BAR_SEGMENTS; i++) begin : g_bar_on
    assign bar_on[i] = ctrl.power_on &&
                       ((CMP_W'(water_fill) > CMP_W'(i)) ||
                        (CMP_W'(foam_fill) >= CMP_W'(BAR_SEGMENTS - i)));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_count <= '0;
      blink_flag  <= 1'b0;
      water_sweep <= '0;
      foam_sweep  <= '0;
    end else if (ctrl.tick) begin
      blink_count <= blink_count_next;
      blink_flag  <= blink_flag_next;
      water_sweep <= ctrl.start_water ? lpfb_pkg::SWEEP_RISING : water_step;
      foam_sweep  <= ctrl.start_foam ? lpfb_pkg::SWEEP_RISING : foam_step;
    end
  end

  for (genvar i = 0; i < BUTTON_LEDS; i++) begin : g_btn_duty
    always_ff @(posedge clk) begin
      if (rst) begin
        button_duty[i] <= '0;
      end else if (ctrl.tick) begin
        button_duty[i] <= ramp(button_duty[i], button_on[i]);
      end
    end
  end

  for (genvar i = 0; i < lpfb_pkg::LOW_LEDS; i++) begin : g_low_duty
    always_ff @(posedge clk) begin
      if (rst) begin
        low_duty[i] <= '0;
      end else if (ctrl.tick) begin
        low_duty[i] <= ramp(low_duty[i], low_on[i]);
      end
    end
  end

  for (genvar i = 0; i < BAR_SEGMENTS; i++) begin : g_bar_duty
    always_ff @(posedge clk) begin
      if (rst) begin
        bar_duty[i] <= '0;
      end else if (ctrl.tick) begin
        bar_duty[i] <= ramp(bar_duty[i], bar_on[i]);
      end
    end
  end

endmodule

@@ hw/rtl/lpfb_pwm.sv @@
// lpfb_pwm: pwm phase counter and per-channel duty compare
// depends on lpfb_pkg
module lpfb_pwm #(
  parameter int BAR_SEGMENTS = lpfb_pkg::BAR_SEGMENTS_DEF,
  parameter int BUTTON_LEDS  = lpfb_pkg::BUTTON_LEDS_DEF,
  parameter int DUTY_STEPS   = lpfb_pkg::DUTY_STEPS_DEF,
  localparam int DW = $clog2(DUTY_STEPS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          tick,
  input  logic [DW-1:0]                 button_duty [BUTTON_LEDS],
  input  logic [DW-1:0]                 low_duty [lpfb_pkg::LOW_LEDS],
  input  logic [DW-1:0]                 bar_duty [BAR_SEGMENTS],
  output logic [BUTTON_LEDS-1:0]        button_leds,
  output logic [lpfb_pkg::LOW_LEDS-1:0] low_leds,
  output logic [BAR_SEGMENTS-1:0]       bar_leds
);

  localparam int PW = $clog2(DUTY_STEPS);

  logic [PW-1:0] phase, phase_next;
  logic [DW-1:0] phase_cmp;

  // phase wraps at the number of duty steps
  assign phase_next = (phase == PW'(DUTY_STEPS - 1)) ? '0 : phase + 1'b1;
  assign phase_cmp  = DW'(phase_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= '0;
    end else if (tick) begin
      phase <= phase_next;
    end
  end

  for (genvar i = 0; i < BUTTON_LEDS; i++) begin : g_btn
    assign button_leds[i] = phase_cmp < button_duty[i];
  end
  for (genvar i = 0; i < lpfb_pkg::LOW_LEDS; i++) begin : g_low
    assign low_leds[i] = phase_cmp < low_duty[i];
  end
  for (genvar i = 0; i < BAR_SEGMENTS; i++) begin : g_bar
    assign bar_leds[i] = phase_cmp < bar_duty[i];
  end

endmodule

@@ hw/rtl/led_pwm_fade_bargraph.sv @@
// led_pwm_fade_bargraph: top level of the soft pwm led driver with fading
// depends on lpfb_pkg, lpfb_if, lpfb_fade and lpfb_pwm
//
// Soft pwm driver for the button leds, the two low-level segments and the
// level bar. Every channel carries a duty level from 0 to DUTY_STEPS. An item
// with cmd fast advances the pwm phase and returns one result with the on/off
// pattern (a channel is on while phase < duty). An item with cmd slow runs one
// fade step: the blink timer, the water and foam scale sweeps, the target
// pattern and a one-step duty ramp toward it; it returns no result. The
// block takes one item per clock while the result side keeps up. An accepted
// item is held in the input register and is processed on the way to the
// result register, which holds the result until it is taken. The input
// register moves on whenever the result register is empty or being taken, so
// throughput stays at one item per cycle while the result side keeps up; a
// slow tick never waits on the result side. blink_half_period is written
// through cfg_wr_en and cfg_wr_data and resets to 20; the user must write it
// only while the block is idle, which the block itself does not enforce.
module led_pwm_fade_bargraph #(
  parameter int BAR_SEGMENTS = lpfb_pkg::BAR_SEGMENTS_DEF,
  parameter int BUTTON_LEDS  = lpfb_pkg::BUTTON_LEDS_DEF,
  parameter int DUTY_STEPS   = lpfb_pkg::DUTY_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wr_en,
  input  logic [lpfb_pkg::PERIOD_W-1:0] cfg_wr_data,
  lpfb_item_if.sink                     item,
  lpfb_result_if.source                 result
);

  localparam int DW = $clog2(DUTY_STEPS + 1);

  // configuration register
  logic [lpfb_pkg::PERIOD_W-1:0] blink_half_period;

  // input register
  logic                         in_valid;
  logic                         in_cmd;
  logic [BUTTON_LEDS-1:0]       in_buttons;
  logic [lpfb_pkg::LEVEL_W-1:0] in_water;
  logic [lpfb_pkg::LEVEL_W-1:0] in_foam;
  logic                         in_power;
  logic                         in_start_water;
  logic                         in_start_foam;

  // result register
  logic                          out_valid;
  logic [BUTTON_LEDS-1:0]        out_buttons;
  logic [lpfb_pkg::LOW_LEDS-1:0] out_low;
  logic [BAR_SEGMENTS-1:0]       out_bar;

  // handshake and datapath wiring
  logic                          in_go;
  logic                          fast_go;
  logic                          item_xfer;
  lpfb_pkg::fade_ctrl_t          fade_ctrl;
  logic [DW-1:0]                 button_duty [BUTTON_LEDS];
  logic [DW-1:0]                 low_duty [lpfb_pkg::LOW_LEDS];
  logic [DW-1:0]                 bar_duty [BAR_SEGMENTS];
  logic [BUTTON_LEDS-1:0]        pwm_buttons;
  logic [lpfb_pkg::LOW_LEDS-1:0] pwm_low;
  logic [BAR_SEGMENTS-1:0]       pwm_bar;

  // slow ticks leave no result, so only fast ticks wait on the result register
  assign in_go = in_valid &&
                 ((in_cmd == lpfb_pkg::CMD_SLOW) || !out_valid || result.ready);
  assign fast_go    = in_go && (in_cmd == lpfb_pkg::CMD_FAST);
  assign item.ready = !in_valid || in_go;
  assign item_xfer  = item.valid && item.ready;

  assign fade_ctrl.tick        = in_go && (in_cmd == lpfb_pkg::CMD_SLOW);
  assign fade_ctrl.power_on    = in_power;
  assign fade_ctrl.start_water = in_start_water;
  assign fade_ctrl.start_foam  = in_start_foam;

  always_ff @(posedge clk) begin
    if (rst) begin
      blink_half_period <= lpfb_pkg::BLINK_PERIOD_RESET;
    end else if (cfg_wr_en) begin
      blink_half_period <= cfg_wr_data;
    end
  end

  // input register control
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  // input register payload
  always_ff @(posedge clk) begin
    if (item_xfer) begin
      in_cmd         <= item.cmd;
      in_buttons     <= item.button_targets;
      in_water       <= item.water_level;
      in_foam        <= item.foam_level;
      in_power       <= item.power_on;
      in_start_water <= item.start_water_anim;
      in_start_foam  <= item.start_foam_anim;
    end
  end

  lpfb_fade #(
    .BAR_SEGMENTS (BAR_SEGMENTS),
    .BUTTON_LEDS  (BUTTON_LEDS),
    .DUTY_STEPS   (DUTY_STEPS)
  ) u_fade (
    .clk               (clk),
    .rst               (rst),
    .ctrl              (fade_ctrl),
    .blink_half_period (blink_half_period),
    .button_targets    (in_buttons),
    .water_level       (in_water),
    .foam_level        (in_foam),
    .button_duty       (button_duty),
    .low_duty          (low_duty),
    .bar_duty          (bar_duty)
  );

  lpfb_pwm #(
    .BAR_SEGMENTS (BAR_SEGMENTS),
    .BUTTON_LEDS  (BUTTON_LEDS),
    .DUTY_STEPS   (DUTY_STEPS)
  ) u_pwm (
    .clk         (clk),
    .rst         (rst),
    .tick        (fast_go),
    .button_duty (button_duty),
    .low_duty    (low_duty),
    .bar_duty    (bar_duty),
    .button_leds (pwm_buttons),
    .low_leds    (pwm_low),
    .bar_leds    (pwm_bar)
  );

  // result register control: a fast tick loads, a transfer empties
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fast_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fast_go) begin
      out_buttons <= pwm_buttons;
      out_low     <= pwm_low;
      out_bar     <= pwm_bar;
    end
  end

  assign result.valid       = out_valid;
  assign result.button_leds = out_buttons;
  assign result.low_leds    = out_low;
  assign result.bar_leds    = out_bar;

endmodule
